/* sv/tct_pkg.sv */
// ----------------------------------------------------------------------------
// tct_pkg: shared definitions for the teletype text console
// Sizes, character codes, action and register codes, state encoding and the
// request structures passed between the sequencer, address unit and store.
// ----------------------------------------------------------------------------
package tct_pkg;

	localparam int CELL_WORDS = 32768;
	localparam int PAGE_CELLS = 2048;
	localparam int PAGE_COUNT = 8;
	localparam int MAX_COLS   = 80;
	localparam int MAX_ROWS   = 50;

	localparam int CELL_AW   = $clog2(CELL_WORDS);
	localparam int CELL_W    = 16;
	localparam int ADDR_W    = 16;
	localparam int ROW_W     = 8;
	localparam int COL_W     = 8;
	localparam int CHAR_W    = 8;
	localparam int PAGE_W    = 3;
	localparam int PG_W      = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
	localparam int COLS_W    = 7;
	localparam int ROWS_W    = 6;
	localparam int CFG_W     = 7;
	localparam int CFG_IDX_W = 2;

	localparam int COLS_DEFAULT = 80;

	localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0720;

	localparam logic [CHAR_W-1:0] CH_BEL = 8'h07;
	localparam logic [CHAR_W-1:0] CH_BS  = 8'h08;
	localparam logic [CHAR_W-1:0] CH_LF  = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_CR  = 8'h0D;

	typedef enum logic [1:0] {
		ACT_PRINT  = 2'd0,
		ACT_READ   = 2'd1,
		ACT_SETCUR = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ACTIVE_PAGE    = 2'd0,
		REG_SCREEN_COLUMNS = 2'd1,
		REG_SCREEN_ROWS    = 2'd2
	} cfg_reg_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_P_ADDR,
		S_P_RD,
		S_P_WR,
		S_R_ADDR,
		S_R_MEM,
		S_R_DATA,
		S_SC_BASE,
		S_SC_INIT,
		S_SC_RD,
		S_SC_WR,
		S_CURS,
		S_DONE
	} state_t;

	typedef struct packed {
		logic              en;
		logic [PAGE_W-1:0] page;
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  col;
	} addr_req_t;

	typedef struct packed {
		logic               we;
		logic [CELL_AW-1:0] waddr;
		logic [CELL_W-1:0]  wdata;
		logic               re;
		logic [CELL_AW-1:0] raddr;
	} mem_req_t;

	// Column count in use: zero means the default width, clamp to the maximum
	function automatic logic [COL_W-1:0] eff_cols(input logic [COLS_W-1:0] c);
		logic [COL_W-1:0] n;
		n = (c == '0) ? COL_W'(COLS_DEFAULT) : COL_W'(c);
		return (n > COL_W'(MAX_COLS)) ? COL_W'(MAX_COLS) : n;
	endfunction

	// Row count in use: zero means one row, clamp to the maximum
	function automatic logic [ROW_W-1:0] eff_rows(input logic [ROWS_W-1:0] r);
		logic [ROW_W-1:0] n;
		n = (r == '0) ? ROW_W'(1) : ROW_W'(r);
		return (n > ROW_W'(MAX_ROWS)) ? ROW_W'(MAX_ROWS) : n;
	endfunction

	function automatic logic [PAGE_W-1:0] page_wrap(input logic [PAGE_W-1:0] p);
		return PAGE_W'(p % PAGE_COUNT);
	endfunction

endpackage

/* sv/text_console_teletype.sv */
// ----------------------------------------------------------------------------
// text_console_teletype: teletype text console with eight cursor pages
// Prints characters teletype style, reads cells and sets page cursors over a
// character/attribute cell store, scrolling the active page when needed.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake            Payload
//  -------  -------------------  ---------------------------------------------
//  in       in_valid / in_stall  action, char_code, page_select, target_row,
//                                target_col
//  out      out_valid/out_stall  pos_row, pos_col, cursor_address,
//                                cell_char, cell_attr
//  cfg      cfg_we               cfg_index, cfg_data
//
//  Transactions are stepped by the sequencer through one shared address unit
//  and the cell store; a print that scrolls also walks the page, reading and
//  writing each copied cell and writing blanks into the last row.
//  After reset a clearing pass writes 0720h to all 32768 cells, one per cycle;
//  in_stall stays high during the pass, configuration writes are taken.
//  A new transaction is taken while a result still waits on out_stall; its
//  result is held back until the pending one is taken.
//
module text_console_teletype (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    action,
	input  logic [tct_pkg::CHAR_W-1:0]    char_code,
	input  logic [tct_pkg::PAGE_W-1:0]    page_select,
	input  logic [tct_pkg::ROW_W-1:0]     target_row,
	input  logic [tct_pkg::COL_W-1:0]     target_col,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [tct_pkg::ROW_W-1:0]     pos_row,
	output logic [tct_pkg::COL_W-1:0]     pos_col,
	output logic [tct_pkg::ADDR_W-1:0]    cursor_address,
	output logic [tct_pkg::CHAR_W-1:0]    cell_char,
	output logic [tct_pkg::CHAR_W-1:0]    cell_attr,
	input  logic                          cfg_we,
	input  logic [tct_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tct_pkg::CFG_W-1:0]     cfg_data
);
	import tct_pkg::*;

	// Configuration registers
	logic [PAGE_W-1:0] active_page_q;
	logic [COLS_W-1:0] screen_columns_q;
	logic [ROWS_W-1:0] screen_rows_q;

	logic [COL_W-1:0]  ncols;
	logic [ROW_W-1:0]  nrows;
	logic [ADDR_W-1:0] addr_s1;
	logic [CELL_W-1:0] rdata;
	logic              clearing;
	addr_req_t         addr_req;
	mem_req_t          mem_req;

	// Take register writes at any time; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_page_q    <= '0;
			screen_columns_q <= COLS_W'(80);
			screen_rows_q    <= ROWS_W'(25);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ACTIVE_PAGE:    active_page_q    <= cfg_data[PAGE_W-1:0];
				REG_SCREEN_COLUMNS: screen_columns_q <= cfg_data[COLS_W-1:0];
				REG_SCREEN_ROWS:    screen_rows_q    <= cfg_data[ROWS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Screen size in use, after the zero and maximum rules
	assign ncols = eff_cols(screen_columns_q);
	assign nrows = eff_rows(screen_rows_q);

	// Sequencer: cursors, control flow and the result register
	tct_seq u_seq (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.action         (action),
		.char_code      (char_code),
		.page_select    (page_select),
		.target_row     (target_row),
		.target_col     (target_col),
		.active_page    (active_page_q),
		.ncols          (ncols),
		.nrows          (nrows),
		.addr_s1        (addr_s1),
		.rdata          (rdata),
		.addr_req       (addr_req),
		.mem_req        (mem_req),
		.clearing       (clearing),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.pos_row        (pos_row),
		.pos_col        (pos_col),
		.cursor_address (cursor_address),
		.cell_char      (cell_char),
		.cell_attr      (cell_attr)
	);

	// Shared address unit: cell addresses, scroll base and display cursor
	tct_addr_unit u_addr (
		.clk    (clk),
		.req    (addr_req),
		.ncols  (ncols),
		.sum_s1 (addr_s1)
	);

	// Cell store
	tct_cell_store u_store (
		.clk     (clk),
		.req     (mem_req),
		.rdata_q (rdata)
	);

	// No result may appear during the clearing pass
	a_no_result_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !out_valid)
		else $error("result valid during clearing pass");

	// The clearing pass writes blank cells only
	a_clear_writes_blank: assert property (@(posedge clk) disable iff (!arst_n)
		(clearing && mem_req.we) |-> (mem_req.wdata == BLANK_CELL))
		else $error("clearing pass wrote a non-blank cell");

	// An accepted transaction never sends the sequencer back to clearing
	a_accept_not_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> !clearing)
		else $error("clearing pass after an accepted transaction");

endmodule

/* sv/tct_addr_unit.sv */
// ----------------------------------------------------------------------------
// tct_addr_unit: shared cell address calculator
// Registers page * page size + row * columns + column, modulo 2^16.
// ----------------------------------------------------------------------------
module tct_addr_unit (
	input  logic                        clk,
	input  tct_pkg::addr_req_t          req,
	input  logic [tct_pkg::COL_W-1:0]   ncols,
	output logic [tct_pkg::ADDR_W-1:0]  sum_s1
);
	import tct_pkg::*;

	logic [ADDR_W-1:0] base;
	logic [ADDR_W-1:0] span;
	logic [ADDR_W-1:0] sum;

	assign base = ADDR_W'(req.page) * ADDR_W'(PAGE_CELLS);
	assign span = ADDR_W'(req.row) * ADDR_W'(ncols);
	assign sum  = base + span + ADDR_W'(req.col);

	always_ff @(posedge clk) begin
		if (req.en) begin
			sum_s1 <= sum;
		end
	end

endmodule

/* sv/tct_cell_store.sv */
// ----------------------------------------------------------------------------
// tct_cell_store: character and attribute cell memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module tct_cell_store (
	input  logic                        clk,
	input  tct_pkg::mem_req_t           req,
	output logic [tct_pkg::CELL_W-1:0]  rdata_q
);
	import tct_pkg::*;

	logic [CELL_W-1:0] mem [CELL_WORDS];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (req.re) begin
			rdata_q <= mem[req.raddr];
		end
	end

endmodule

/* sv/tct_seq.sv */
// ----------------------------------------------------------------------------
// tct_seq: transaction sequencer for the teletype console
// Holds the page cursors, steps prints, reads, scrolls and the clearing pass,
// and keeps the result register.
// ----------------------------------------------------------------------------
module tct_seq (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [1:0]                  action,
	input  logic [tct_pkg::CHAR_W-1:0]  char_code,
	input  logic [tct_pkg::PAGE_W-1:0]  page_select,
	input  logic [tct_pkg::ROW_W-1:0]   target_row,
	input  logic [tct_pkg::COL_W-1:0]   target_col,
	input  logic [tct_pkg::PAGE_W-1:0]  active_page,
	input  logic [tct_pkg::COL_W-1:0]   ncols,
	input  logic [tct_pkg::ROW_W-1:0]   nrows,
	input  logic [tct_pkg::ADDR_W-1:0]  addr_s1,
	input  logic [tct_pkg::CELL_W-1:0]  rdata,
	output tct_pkg::addr_req_t          addr_req,
	output tct_pkg::mem_req_t           mem_req,
	output logic                        clearing,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [tct_pkg::ROW_W-1:0]   pos_row,
	output logic [tct_pkg::COL_W-1:0]   pos_col,
	output logic [tct_pkg::ADDR_W-1:0]  cursor_address,
	output logic [tct_pkg::CHAR_W-1:0]  cell_char,
	output logic [tct_pkg::CHAR_W-1:0]  cell_attr
);
	import tct_pkg::*;

	state_t state_q, state_d;

	logic [ROW_W+COL_W-1:0] cursor_q [PAGE_COUNT];

	logic [CHAR_W-1:0]  ch_q;
	logic [PAGE_W-1:0]  psel_q;
	logic [ROW_W-1:0]   trow_q;
	logic [COL_W-1:0]   tcol_q;
	logic [CELL_W-1:0]  cell_q;
	logic [CELL_AW-1:0] clr_q;
	logic [CELL_AW-1:0] dst_q;
	logic [ROW_W-1:0]   sr_q;
	logic [COL_W-1:0]   sc_q;

	logic               out_valid_q;
	logic [ROW_W-1:0]   row_q;
	logic [COL_W-1:0]   col_q;
	logic [ADDR_W-1:0]  addr_q;
	logic [CELL_W-1:0]  outcell_q;

	logic [PAGE_W-1:0]  apg;
	logic [PG_W-1:0]    apg_idx;
	logic [PG_W-1:0]    psel_idx;
	logic [ROW_W-1:0]   cur_row;
	logic [COL_W-1:0]   cur_col;
	logic               accept;
	logic               is_ctrl;
	logic [ROW_W:0]     new_row;
	logic [COL_W:0]     new_col;
	logic               need_scroll;
	logic [ROW_W-1:0]   fin_row;
	logic               sc_copy;
	logic               sc_last;
	logic               out_load;

	assign apg      = page_wrap(active_page);
	assign apg_idx  = PG_W'(apg);
	assign psel_idx = PG_W'(page_wrap(page_select));
	assign cur_row  = cursor_q[apg_idx][ROW_W+COL_W-1:COL_W];
	assign cur_col  = cursor_q[apg_idx][COL_W-1:0];
	assign accept   = in_valid && !in_stall;

	// Teletype cursor step for the latched character
	assign is_ctrl = (ch_q == CH_BEL) || (ch_q == CH_BS) || (ch_q == CH_LF)
		|| (ch_q == CH_CR);

	always_comb begin
		new_row = {1'b0, cur_row};
		new_col = {1'b0, cur_col};
		priority if (ch_q == CH_BEL) begin
			new_row = {1'b0, cur_row};
		end else if (ch_q == CH_BS) begin
			if (cur_col != '0) begin
				new_col = {1'b0, cur_col} - (COL_W+1)'(1);
			end
		end else if (ch_q == CH_LF) begin
			new_row = {1'b0, cur_row} + (ROW_W+1)'(1);
		end else if (ch_q == CH_CR) begin
			new_col = '0;
		end else begin
			new_col = {1'b0, cur_col} + (COL_W+1)'(1);
			if (new_col >= {1'b0, ncols}) begin
				new_col = '0;
				new_row = {1'b0, cur_row} + (ROW_W+1)'(1);
			end
		end
	end

	assign need_scroll = new_row >= {1'b0, nrows};
	assign fin_row     = need_scroll ? (nrows - ROW_W'(1)) : new_row[ROW_W-1:0];

	assign sc_copy = sr_q != (nrows - ROW_W'(1));
	assign sc_last = !sc_copy && (sc_q == (ncols - COL_W'(1)));

	assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (clr_q == CELL_AW'(CELL_WORDS - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					unique case (action_t'(action))
						ACT_PRINT:  state_d = S_P_ADDR;
						ACT_READ:   state_d = S_R_ADDR;
						ACT_SETCUR: state_d = S_CURS;
						ACT_NONE:   state_d = S_CURS;
					endcase
				end
			end
			S_P_ADDR:  state_d = S_P_RD;
			S_P_RD:    state_d = S_P_WR;
			S_P_WR:    state_d = need_scroll ? S_SC_BASE : S_CURS;
			S_R_ADDR:  state_d = S_R_MEM;
			S_R_MEM:   state_d = S_R_DATA;
			S_R_DATA:  state_d = S_CURS;
			S_SC_BASE: state_d = S_SC_INIT;
			S_SC_INIT: state_d = S_SC_RD;
			S_SC_RD:   state_d = S_SC_WR;
			S_SC_WR:   state_d = sc_last ? S_CURS : S_SC_RD;
			S_CURS:    state_d = S_DONE;
			S_DONE: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default:   state_d = S_IDLE;
		endcase
	end

	// Requests to the address unit and the cell store
	always_comb begin
		addr_req = '0;
		mem_req  = '0;
		in_stall = state_q != S_IDLE;
		clearing = state_q == S_CLEAR;
		unique case (state_q)
			S_CLEAR: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = clr_q;
				mem_req.wdata = BLANK_CELL;
			end
			S_P_ADDR, S_CURS: begin
				addr_req.en   = 1'b1;
				addr_req.page = apg;
				addr_req.row  = cur_row;
				addr_req.col  = cur_col;
			end
			S_P_RD, S_R_MEM: begin
				mem_req.re    = 1'b1;
				mem_req.raddr = addr_s1[CELL_AW-1:0];
			end
			S_P_WR: begin
				mem_req.we    = !is_ctrl;
				mem_req.waddr = addr_s1[CELL_AW-1:0];
				mem_req.wdata = {rdata[CELL_W-1:CHAR_W], ch_q};
			end
			S_R_ADDR: begin
				addr_req.en   = 1'b1;
				addr_req.page = psel_q;
				addr_req.row  = trow_q;
				addr_req.col  = tcol_q;
			end
			S_SC_BASE: begin
				addr_req.en   = 1'b1;
				addr_req.page = apg;
			end
			S_SC_RD: begin
				mem_req.re    = sc_copy;
				mem_req.raddr = dst_q + CELL_AW'(ncols);
			end
			S_SC_WR: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = dst_q;
				mem_req.wdata = sc_copy ? rdata : BLANK_CELL;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < PAGE_COUNT; i++) begin
				cursor_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + CELL_AW'(1);
			end
			if (accept && (action_t'(action) == ACT_SETCUR)) begin
				cursor_q[psel_idx] <= {target_row, target_col};
			end
			if (state_q == S_P_WR) begin
				cursor_q[apg_idx] <= {fin_row, new_col[COL_W-1:0]};
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload and walk registers
	always_ff @(posedge clk) begin
		if (accept) begin
			ch_q   <= char_code;
			psel_q <= page_wrap(page_select);
			trow_q <= target_row;
			tcol_q <= target_col;
			cell_q <= '0;
		end
		if (state_q == S_R_DATA) begin
			cell_q <= rdata;
		end
		if (state_q == S_SC_INIT) begin
			dst_q <= addr_s1[CELL_AW-1:0];
			sr_q  <= '0;
			sc_q  <= '0;
		end
		if (state_q == S_SC_WR) begin
			dst_q <= dst_q + CELL_AW'(1);
			if (sc_q == (ncols - COL_W'(1))) begin
				sc_q <= '0;
				sr_q <= sr_q + ROW_W'(1);
			end else begin
				sc_q <= sc_q + COL_W'(1);
			end
		end
		if (out_load) begin
			row_q     <= cur_row;
			col_q     <= cur_col;
			addr_q    <= addr_s1;
			outcell_q <= cell_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign pos_row        = row_q;
	assign pos_col        = col_q;
	assign cursor_address = addr_q;
	assign cell_char      = outcell_q[CHAR_W-1:0];
	assign cell_attr      = outcell_q[CELL_W-1:CHAR_W];

endmodule
